// ===== rtl/aes192_key_expansion_step_macros.svh =====
// Assertion macros shared by the AES-192 key expansion RTL.
`ifndef AES192_KEY_EXPANSION_STEP_MACROS_SVH
`define AES192_KEY_EXPANSION_STEP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle.
`define KE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aes192ke_pkg.sv =====
// Types, S-box and round constants for the AES-192 key expansion step.
package aes192ke_pkg;

    typedef struct packed {
        logic [31:0] prev_word_0;
        logic [31:0] prev_word_1;
        logic [31:0] prev_word_2;
        logic [31:0] prev_word_3;
        logic [31:0] prev_word_4;
        logic [31:0] prev_word_5;
        logic [3:0]  round_number;
    } ke_req_t;

    typedef struct packed {
        logic [31:0] next_word_0;
        logic [31:0] next_word_1;
        logic [31:0] next_word_2;
        logic [31:0] next_word_3;
        logic [31:0] next_word_4;
        logic [31:0] next_word_5;
    } ke_rsp_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Round constant for rounds 1..12; any other round number gets zero.
    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] rc;
        unique case (rnd)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            4'd11:   rc = 8'h6c;
            4'd12:   rc = 8'hd8;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // RotWord then SubWord: b3 b2 b1 b0 -> S(b2) S(b1) S(b0) S(b3).
    function automatic logic [31:0] rot_sub_word(input logic [31:0] w);
        return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    endfunction

endpackage

// ===== rtl/aes192_key_expansion_step.sv =====
// AES-192 key expansion step: six old schedule words in, six new words out.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   req     | req_valid/req_stall  | req_beat: prev_word_0..5, round_number
//   rsp     | rsp_valid/rsp_stall  | rsp_beat: next_word_0..5
//
// rsp_valid rises when out_reg loads in_reg; one beat per cycle while unstalled.
// The S-box lookups and XOR chain sit between the input and result registers.
// rst_n clears both stage valid flags; payload registers are not reset.
// A stalled rsp holds the result register; req_stall rises only when both
// stages are full and the result is still stalled.
`include "aes192_key_expansion_step_macros.svh"

module aes192_key_expansion_step
    import aes192ke_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    input  ke_req_t req_beat,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output ke_rsp_t rsp_beat
);

    logic    in_valid_reg;
    ke_req_t in_reg;
    logic    out_valid_reg;
    ke_rsp_t out_reg;

    logic    out_free;
    logic    in_free;
    logic    req_take;
    logic    out_load;
    ke_rsp_t out_next;
    logic [31:0] first_word;

    assign out_free = !out_valid_reg || !rsp_stall;
    assign in_free  = !in_valid_reg || out_free;
    assign req_take = req_valid && in_free;
    assign out_load = in_valid_reg && out_free;

    always_comb
    begin
        first_word = rot_sub_word(in_reg.prev_word_5) ^ in_reg.prev_word_0 ^
                     {rcon(in_reg.round_number), 24'h000000};
        out_next.next_word_0 = first_word;
        out_next.next_word_1 = out_next.next_word_0 ^ in_reg.prev_word_1;
        out_next.next_word_2 = out_next.next_word_1 ^ in_reg.prev_word_2;
        out_next.next_word_3 = out_next.next_word_2 ^ in_reg.prev_word_3;
        out_next.next_word_4 = out_next.next_word_3 ^ in_reg.prev_word_4;
        out_next.next_word_5 = out_next.next_word_4 ^ in_reg.prev_word_5;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_reg <= req_beat;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign req_stall = !in_free;
    assign rsp_valid = out_valid_reg;
    assign rsp_beat  = out_reg;

    `KE_ASSERT_NEXT(a_take_fills_input, req_valid && !req_stall, in_valid_reg,
        "accepted req beat did not reach the input register")
    `KE_ASSERT_NEXT(a_blocked_input_holds, in_valid_reg && !out_free,
        in_valid_reg && $stable(in_reg), "input register changed while blocked")
    `KE_ASSERT_NOW(a_no_stall_when_result_empty, !rsp_valid, !req_stall,
        "req stalled although the result register is empty")
    `KE_ASSERT_NEXT(a_result_follows_input, in_valid_reg && out_free, rsp_valid,
        "result register did not take the pending beat")

endmodule

// ===== tb/sv/aes192_key_expansion_step_tb.sv =====
// Self-checking testbench for the AES-192 key expansion step.
`timescale 1ns / 1ps

module aes192_key_expansion_step_tb;
    import aes192ke_pkg::*;

    localparam int CLK_HALF_NS     = 2;
    localparam int RESET_CYCLES    = 2;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTED    = 10;
    localparam int WORDS           = 6;
    localparam int LAST_RCON_ROUND = 12;
    localparam int SCHEDULE_STEPS  = 8;

    logic    clk;
    logic    rst_n;
    logic    req_valid;
    logic    req_stall;
    ke_req_t req_beat;
    logic    rsp_valid;
    logic    rsp_stall;
    ke_rsp_t rsp_beat;

    ke_rsp_t pending_next_keys[$];
    int      send_idle_pct;
    int      recv_stall_pct;
    int      cycle_count;
    int      beats_checked;
    int      mismatch_count;
    int      chains_run;

    aes192_key_expansion_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // GF(2^8) arithmetic, reduction polynomial x^8 + x^4 + x^3 + x + 1
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = 8'h00;
        sh  = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= sh;
            sh = gf_xtime(sh);
        end
        return acc;
    endfunction

    // S-box from first principles: multiplicative inverse (a^254) then affine map
    function automatic logic [7:0] subst_byte(input logic [7:0] a);
        logic [7:0] inv;
        logic [7:0] base;
        int         e;
        inv  = 8'h01;
        base = a;
        e    = 254;
        while (e != 0)
        begin
            if (e & 1)
                inv = gf_mul(inv, base);
            base = gf_mul(base, base);
            e    = e >> 1;
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
               {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [7:0] round_key_const(input logic [3:0] rnd);
        logic [7:0] c;
        if (rnd == 0 || rnd > LAST_RCON_ROUND)
            return 8'h00;
        c = 8'h01;
        for (int i = 1; i < rnd; i++)
            c = gf_xtime(c);
        return c;
    endfunction

    function automatic ke_rsp_t next_key_block(input ke_req_t b);
        logic [31:0] old_w[WORDS];
        logic [31:0] t;
        logic [WORDS*32-1:0] flat;
        old_w = '{b.prev_word_0, b.prev_word_1, b.prev_word_2,
                  b.prev_word_3, b.prev_word_4, b.prev_word_5};
        t = {subst_byte(old_w[5][23:16]), subst_byte(old_w[5][15:8]),
             subst_byte(old_w[5][7:0]), subst_byte(old_w[5][31:24])};
        t = t ^ old_w[0] ^ {round_key_const(b.round_number), 24'h0};
        flat[WORDS*32-1 -: 32] = t;
        for (int i = 1; i < WORDS; i++)
        begin
            t = t ^ old_w[i];
            flat[WORDS*32-1-32*i -: 32] = t;
        end
        return ke_rsp_t'(flat);
    endfunction

    function automatic ke_req_t key_block(input logic [31:0] w0, input logic [31:0] w1,
                                          input logic [31:0] w2, input logic [31:0] w3,
                                          input logic [31:0] w4, input logic [31:0] w5,
                                          input logic [3:0] rnd);
        ke_req_t b;
        b.prev_word_0  = w0;
        b.prev_word_1  = w1;
        b.prev_word_2  = w2;
        b.prev_word_3  = w3;
        b.prev_word_4  = w4;
        b.prev_word_5  = w5;
        b.round_number = rnd;
        return b;
    endfunction

    // Entered and left at a falling edge; one beat per call.
    task automatic send_key_block(input ke_req_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= b;
        do
            @(posedge clk);
        while (req_stall);
        pending_next_keys.push_back(next_key_block(b));
        @(negedge clk);
    endtask

    task automatic test_round_constants();
        for (int r = 0; r < 16; r++)
            send_key_block(key_block('0, '0, '0, '0, '0, '0, r[3:0]));
    endtask

    task automatic test_field_extremes();
        send_key_block(key_block('1, '1, '1, '1, '1, '1, 4'd15));
        send_key_block(key_block('1, '1, '1, '1, '1, '1, 4'd12));
        send_key_block(key_block(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                                 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 4'd5));
        send_key_block(key_block(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                                 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 4'd10));
        // known AES-192 cipher key, first expansion step
        send_key_block(key_block(32'h8e73_b0f7, 32'hda0e_6452, 32'hc810_f32b,
                                 32'h8090_79e5, 32'h62f8_ead2, 32'h522c_6b7b, 4'd1));
    endtask

    // Full key schedules: each step's output is fed back as the next input.
    task automatic test_schedule_chains(input int n_chains);
        ke_req_t b;
        ke_rsp_t k;
        for (int c = 0; c < n_chains; c++)
        begin
            b = key_block($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), 4'd1);
            for (int s = 1; s <= SCHEDULE_STEPS; s++)
            begin
                b.round_number = s[3:0];
                send_key_block(b);
                k = next_key_block(b);
                b = key_block(k.next_word_0, k.next_word_1, k.next_word_2,
                              k.next_word_3, k.next_word_4, k.next_word_5, 4'd0);
            end
            chains_run++;
        end
    endtask

    task automatic test_random_blocks(input int n);
        for (int i = 0; i < n; i++)
            send_key_block(key_block($urandom(), $urandom(), $urandom(), $urandom(),
                                     $urandom(), $urandom(), 4'($urandom_range(15))));
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("[%0t] %s: expected %08h, got %08h", $realtime, what, want, got);
    endtask

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin : check_rsp
        ke_rsp_t             want;
        logic [WORDS*32-1:0] got_flat;
        logic [WORDS*32-1:0] want_flat;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_next_keys.size() == 0)
            begin
                note_mismatch("result beat with nothing pending", rsp_beat.next_word_0, '0);
            end
            else
            begin
                want      = pending_next_keys.pop_front();
                got_flat  = rsp_beat;
                want_flat = want;
                for (int i = 0; i < WORDS; i++)
                    if (got_flat[WORDS*32-1-32*i -: 32] !== want_flat[WORDS*32-1-32*i -: 32])
                        note_mismatch($sformatf("next_word_%0d", i),
                                      got_flat[WORDS*32-1-32*i -: 32],
                                      want_flat[WORDS*32-1-32*i -: 32]);
            end
            beats_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("aes192_key_expansion_step: mismatch");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_beat       = '0;
        rsp_stall      = 1'b0;
        cycle_count    = 0;
        beats_checked  = 0;
        mismatch_count = 0;
        chains_run     = 0;
        send_idle_pct  = 32;
        recv_stall_pct = 53;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_round_constants();
        test_field_extremes();
        test_schedule_chains(20);
        test_random_blocks(40);

        send_idle_pct  = 53;
        recv_stall_pct = 32;
        test_schedule_chains(20);
        test_random_blocks(40);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_schedule_chains(20);
        test_random_blocks(40);

        req_valid <= 1'b0;
        while (pending_next_keys.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result beats: all 16 round numbers, word extremes,",
                 beats_checked);
        $display("%0d chained key schedules and random blocks under three stall mixes.",
                 chains_run);
        if (mismatch_count == 0)
            $display("aes192_key_expansion_step: match");
        else
            $display("aes192_key_expansion_step: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/aes192ke_pkg.sv
rtl/aes192_key_expansion_step.sv
tb/sv/aes192_key_expansion_step_tb.sv
